### design/itr_pkg.sv
// itr_pkg: shared types, constants and numeral lookup functions
// for the integer to roman numeral converter; no dependencies
package itr_pkg;

	localparam int VALUE_W  = 10;
	localparam int SYMBOL_W = 7;

	localparam logic [VALUE_W-1:0] VALUE_MAX = VALUE_W'(1000);

	localparam logic [SYMBOL_W-1:0] CH_NONE = 7'h00;
	localparam logic [SYMBOL_W-1:0] CH_I    = 7'h49;
	localparam logic [SYMBOL_W-1:0] CH_V    = 7'h56;
	localparam logic [SYMBOL_W-1:0] CH_X    = 7'h58;
	localparam logic [SYMBOL_W-1:0] CH_L    = 7'h4c;
	localparam logic [SYMBOL_W-1:0] CH_C    = 7'h43;
	localparam logic [SYMBOL_W-1:0] CH_D    = 7'h44;
	localparam logic [SYMBOL_W-1:0] CH_M    = 7'h4d;

	typedef enum logic [1:0] {
		KIND_ONE,
		KIND_FIVE,
		KIND_TEN
	} kind_t;

	typedef struct packed {
		logic load;
		logic split;
		logic emit;
	} itr_cmd_t;

	typedef struct packed {
		logic last;
	} itr_sts_t;

	// number of letters a decimal digit writes
	function automatic logic [2:0] digit_len(input logic [3:0] d);
		logic [2:0] len;
		begin
			case (d)
				4'd1, 4'd5:        len = 3'd1;
				4'd2, 4'd4, 4'd6,
				4'd9:              len = 3'd2;
				4'd3, 4'd7:        len = 3'd3;
				4'd8:              len = 3'd4;
				default:           len = 3'd0;
			endcase
			return len;
		end
	endfunction

	// which letter of its place the k-th letter of digit d is
	function automatic kind_t sym_kind(input logic [3:0] d, input logic [1:0] k);
		kind_t kind;
		begin
			case (d)
				4'd4:                    kind = (k == 2'd0) ? KIND_ONE : KIND_FIVE;
				4'd9:                    kind = (k == 2'd0) ? KIND_ONE : KIND_TEN;
				4'd5, 4'd6, 4'd7, 4'd8:  kind = (k == 2'd0) ? KIND_FIVE : KIND_ONE;
				default:                 kind = KIND_ONE;
			endcase
			return kind;
		end
	endfunction

	// ascii letter for a kind at a decimal place (0 units .. 3 thousands)
	function automatic logic [SYMBOL_W-1:0] sym_char(input kind_t kind, input logic [1:0] pos);
		logic [SYMBOL_W-1:0] ch;
		begin
			ch = CH_NONE;
			unique case (kind)
				KIND_ONE: begin
					case (pos)
						2'd0:    ch = CH_I;
						2'd1:    ch = CH_X;
						2'd2:    ch = CH_C;
						default: ch = CH_M;
					endcase
				end
				KIND_FIVE: begin
					case (pos)
						2'd0:    ch = CH_V;
						2'd1:    ch = CH_L;
						default: ch = CH_D;
					endcase
				end
				KIND_TEN: begin
					case (pos)
						2'd0:    ch = CH_X;
						2'd1:    ch = CH_C;
						default: ch = CH_M;
					endcase
				end
				default: ch = CH_NONE;
			endcase
			return ch;
		end
	endfunction

endpackage

### design/itr_if.sv
// itr_in_if, itr_out_if: valid/ready channels for number and letter transactions
// depends on itr_pkg
interface itr_in_if;
	logic                        valid;
	logic                        ready;
	logic [itr_pkg::VALUE_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface itr_out_if;
	logic                         valid;
	logic                         ready;
	logic [itr_pkg::SYMBOL_W-1:0] symbol;
	logic                         last;
	logic                         out_of_range;

	modport source (output valid, output symbol, output last, output out_of_range, input ready);
	modport sink   (input valid, input symbol, input last, input out_of_range, output ready);
endinterface

### design/integer_to_roman_numeral.sv
// integer_to_roman_numeral: top level joining controller and datapath
// depends on itr_pkg, itr_if, itr_ctrl, itr_dp
//
//   channel  dir  payload                        meaning
//   din      in   value[9:0]                     number to convert
//   dout     out  symbol[6:0] last out_of_range  one numeral letter per transaction
//
// a number writes n letters, n the letter count (1 to 12)
// the load splits off hundreds, the split state splits tens and units,
// then the letter sequencer emits one letter per unstalled cycle into the output register
// din is ready only between numbers; the last letter may still wait in the output register
// a stall on dout holds the sequencer; reset clears the controller only
module integer_to_roman_numeral (
	input  logic       clk,
	input  logic       arst_n,
	itr_in_if.sink     din,
	itr_out_if.source  dout
);

	itr_pkg::itr_cmd_t cmd;
	itr_pkg::itr_sts_t sts;

	itr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (din.valid),
		.in_ready  (din.ready),
		.out_valid (dout.valid),
		.out_ready (dout.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	itr_dp u_dp (
		.clk          (clk),
		.cmd          (cmd),
		.value        (din.value),
		.sts          (sts),
		.symbol       (dout.symbol),
		.last         (dout.last),
		.out_of_range (dout.out_of_range)
	);

	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && dout.out_of_range |-> dout.last && (dout.symbol == itr_pkg::CH_NONE))
		else $error("error transaction not a single zero letter");

	a_letter_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && !dout.out_of_range |-> dout.symbol != itr_pkg::CH_NONE)
		else $error("valid numeral letter is zero");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		din.valid && din.ready |=> !din.ready)
		else $error("new number taken before previous one finished");

endmodule

### design/itr_dp.sv
// itr_dp: digit split and letter generation datapath with output payload register
// depends on itr_pkg
module itr_dp (
	input  logic                         clk,
	input  itr_pkg::itr_cmd_t            cmd,
	input  logic [itr_pkg::VALUE_W-1:0]  value,
	output itr_pkg::itr_sts_t            sts,
	output logic [itr_pkg::SYMBOL_W-1:0] symbol,
	output logic                         last,
	output logic                         out_of_range
);

	logic [3:0]  hund_q;
	logic [6:0]  rem_q;
	logic        err_q;
	logic        thou_q;
	logic [3:0]  dig_q [4];
	logic [1:0]  pos_q;
	logic [1:0]  k_q;

	logic [itr_pkg::SYMBOL_W-1:0] symbol_q;
	logic                         last_q;
	logic                         oor_q;

	// hundreds by reciprocal multiply, valid below 1024
	logic [15:0] prod_h;
	logic [3:0]  hund;
	logic [9:0]  rem_full;

	// tens and units from the remainder
	logic [13:0] prod_t;
	logic [3:0]  tens;
	logic [6:0]  tens_x10;
	logic [6:0]  units_full;
	logic [3:0]  split_dig [4];
	logic [1:0]  start_pos;

	logic [3:0]       cur_dig;
	logic [2:0]       cur_len;
	itr_pkg::kind_t   cur_kind;
	logic             end_of_dig;
	logic             lower_nz;
	logic [1:0]       next_pos;
	logic             char_last;

	always_comb begin
		prod_h   = 16'(value) * 16'd41;
		hund     = prod_h[15:12];
		rem_full = value - (10'(hund) * 10'd100);
	end

	always_comb begin
		prod_t       = 14'(rem_q) * 14'd103;
		tens         = prod_t[13:10];
		tens_x10     = {tens[3:0], 3'b000} + {2'b00, tens[3:0], 1'b0};
		units_full   = rem_q - tens_x10;
		split_dig[3] = {3'b000, thou_q};
		split_dig[2] = thou_q ? 4'd0 : hund_q;
		split_dig[1] = thou_q ? 4'd0 : tens;
		split_dig[0] = thou_q ? 4'd0 : units_full[3:0];
		start_pos    = 2'd0;
		for (int i = 0; i < 4; i++) begin
			if (split_dig[i] != 4'd0) start_pos = 2'(i);
		end
	end

	always_comb begin
		cur_dig    = dig_q[pos_q];
		cur_len    = itr_pkg::digit_len(cur_dig);
		cur_kind   = itr_pkg::sym_kind(cur_dig, k_q);
		end_of_dig = ({1'b0, k_q} + 3'd1) >= cur_len;
		lower_nz   = 1'b0;
		next_pos   = 2'd0;
		for (int i = 0; i < 4; i++) begin
			if ((2'(i) < pos_q) && (dig_q[i] != 4'd0)) begin
				lower_nz = 1'b1;
				next_pos = 2'(i);
			end
		end
		char_last = err_q || (end_of_dig && !lower_nz);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			err_q  <= (value == '0) || (value > itr_pkg::VALUE_MAX);
			thou_q <= (value == itr_pkg::VALUE_MAX);
			hund_q <= hund;
			rem_q  <= rem_full[6:0];
		end
		if (cmd.split) begin
			for (int i = 0; i < 4; i++) begin
				dig_q[i] <= split_dig[i];
			end
			pos_q <= start_pos;
			k_q   <= 2'd0;
		end
		if (cmd.emit) begin
			symbol_q <= err_q ? itr_pkg::CH_NONE : itr_pkg::sym_char(cur_kind, pos_q);
			last_q   <= char_last;
			oor_q    <= err_q;
			if (end_of_dig) begin
				pos_q <= next_pos;
				k_q   <= 2'd0;
			end else begin
				k_q <= k_q + 2'd1;
			end
		end
	end

	assign sts.last     = char_last;
	assign symbol       = symbol_q;
	assign last         = last_q;
	assign out_of_range = oor_q;

endmodule

### design/itr_ctrl.sv
// itr_ctrl: controller state machine sequencing load, split and letter emission
// depends on itr_pkg
module itr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  itr_pkg::itr_sts_t sts,
	output itr_pkg::itr_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SPLIT,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.load  = (state_q == ST_IDLE) && in_valid;
		cmd.split = (state_q == ST_SPLIT);
		cmd.emit  = (state_q == ST_EMIT) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_SPLIT;
				end
				ST_SPLIT: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (cmd.emit && sts.last) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// one command at a time
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.split, cmd.emit}))
		else $error("controller issued overlapping commands");

endmodule
